/* src/sqc_pkg.sv */
`default_nettype none

package sqc_pkg;

    localparam int COORD_BITS = 16;
    localparam int TOL_BITS   = 20;
    localparam int NUM_CORNER = 4;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CMP_W      = ((SUM_W > TOL_BITS) ? SUM_W : TOL_BITS) + 1;
    localparam int IN_BITS    = 4 * COORD_BITS + 2 * NUM_CORNER * COORD_BITS;
    localparam int IN_BYTES_W = ((IN_BITS + 7) / 8) * 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [CMP_W-1:0]      cmp_t;
    typedef logic [TOL_BITS-1:0]          tol_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_CORNER = 2'd1,
        KIND_EDGE   = 2'd2
    } hit_kind_t;

    function automatic diff_t sub_coord(coord_t a, coord_t b);
        diff_t ea;
        diff_t eb;
        ea = {a[COORD_BITS-1], a};
        eb = {b[COORD_BITS-1], b};
        return ea - eb;
    endfunction

    function automatic prod_t mul_diff(diff_t a, diff_t b);
        prod_t r;
        r = a * b;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/segment_quad_collision_core.sv */
`default_nettype none

// Channel  Dir  Beat accepted at             Content
// s_axis   in   s_tvalid && s_tready         segment A, B and corners 0..3
// m_axis   out  m_tvalid && m_tready         hit, hit_index; hit_kind in tuser
// cfg      in   cfg_wen                      zero_tolerance
//
// Four register stages: differences and bounding boxes, products, sums,
// then tests and priority into the output register. One beat per cycle
// flows while m_tready is high; the 17x17 multipliers set the stage depth.
// rst_n clears the stage valid bits and zero_tolerance.
// Each stage holds only while it is full and the stage after it is full
// and stalled, so bubbles close up under backpressure.
module segment_quad_collision_core
    import sqc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // lowest bit up: seg_ax, seg_ay, seg_bx, seg_by, corner0_x, corner0_y,
    // corner1_x, corner1_y, corner2_x, corner2_y, corner3_x, corner3_y
    input  wire logic [IN_BYTES_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // lowest bit up: hit, hit_index[1:0], zero fill
    output logic [7:0]                 m_tdata,
    // lowest bit up: hit_kind[1:0]
    output logic [1:0]                 m_tuser,
    input  wire logic                  cfg_wen,
    input  wire logic [TOL_BITS-1:0]   cfg_wdata
);

    tol_t tol_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
        end
        else if (cfg_wen)
        begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // ---------------- stage 1: differences and bounding boxes
    coord_t ax, ay, bx, by;
    coord_t cx [NUM_CORNER];
    coord_t cy [NUM_CORNER];

    always_comb
    begin
        ax = s_tdata[0*COORD_BITS +: COORD_BITS];
        ay = s_tdata[1*COORD_BITS +: COORD_BITS];
        bx = s_tdata[2*COORD_BITS +: COORD_BITS];
        by = s_tdata[3*COORD_BITS +: COORD_BITS];
        for (int i = 0; i < NUM_CORNER; i++)
        begin
            cx[i] = s_tdata[(4 + 2*i)*COORD_BITS +: COORD_BITS];
            cy[i] = s_tdata[(5 + 2*i)*COORD_BITS +: COORD_BITS];
        end
    end

    function automatic logic span_overlap(coord_t a, coord_t b, coord_t e, coord_t f);
        coord_t lo_ab;
        coord_t hi_ab;
        coord_t lo_ef;
        coord_t hi_ef;
        lo_ab = (a < b) ? a : b;
        hi_ab = (a > b) ? a : b;
        lo_ef = (e < f) ? e : f;
        hi_ef = (e > f) ? e : f;
        return (lo_ab <= hi_ef) && (lo_ef <= hi_ab);
    endfunction

    diff_t dx_reg, dy_reg;
    diff_t ux_reg [NUM_CORNER];
    diff_t uy_reg [NUM_CORNER];
    diff_t wx_reg [NUM_CORNER];
    diff_t wy_reg [NUM_CORNER];
    diff_t fx_reg [NUM_CORNER];
    diff_t fy_reg [NUM_CORNER];
    logic [NUM_CORNER-1:0] box1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx_reg <= sub_coord(bx, ax);
            dy_reg <= sub_coord(by, ay);
            for (int i = 0; i < NUM_CORNER; i++)
            begin
                ux_reg[i] <= sub_coord(cx[i], ax);
                uy_reg[i] <= sub_coord(cy[i], ay);
                wx_reg[i] <= sub_coord(cx[i], bx);
                wy_reg[i] <= sub_coord(cy[i], by);
                fx_reg[i] <= sub_coord(cx[i], cx[(i + 1) % NUM_CORNER]);
                fy_reg[i] <= sub_coord(cy[i], cy[(i + 1) % NUM_CORNER]);
                box1_reg[i] <= span_overlap(ax, bx, cx[i], cx[(i + 1) % NUM_CORNER])
                            && span_overlap(ay, by, cy[i], cy[(i + 1) % NUM_CORNER]);
            end
        end
    end

    // ---------------- stage 2: products
    // Edge crosses are formed with both sides negated; sign pairs and
    // magnitudes are unchanged by that.
    prod_t p_uxdy_reg [NUM_CORNER];
    prod_t p_uydx_reg [NUM_CORNER];
    prod_t p_uxdx_reg [NUM_CORNER];
    prod_t p_uydy_reg [NUM_CORNER];
    prod_t p_wxdx_reg [NUM_CORNER];
    prod_t p_wydy_reg [NUM_CORNER];
    prod_t p_dxwy_reg [NUM_CORNER];
    prod_t p_dywx_reg [NUM_CORNER];
    prod_t p_fxuy_reg [NUM_CORNER];
    prod_t p_fyux_reg [NUM_CORNER];
    prod_t p_fxwy_reg [NUM_CORNER];
    prod_t p_fywx_reg [NUM_CORNER];
    logic [NUM_CORNER-1:0] box2_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            box2_reg <= box1_reg;
            for (int i = 0; i < NUM_CORNER; i++)
            begin
                p_uxdy_reg[i] <= mul_diff(ux_reg[i], dy_reg);
                p_uydx_reg[i] <= mul_diff(uy_reg[i], dx_reg);
                p_uxdx_reg[i] <= mul_diff(ux_reg[i], dx_reg);
                p_uydy_reg[i] <= mul_diff(uy_reg[i], dy_reg);
                p_wxdx_reg[i] <= mul_diff(wx_reg[i], dx_reg);
                p_wydy_reg[i] <= mul_diff(wy_reg[i], dy_reg);
                p_dxwy_reg[i] <= mul_diff(dx_reg, wy_reg[i]);
                p_dywx_reg[i] <= mul_diff(dy_reg, wx_reg[i]);
                p_fxuy_reg[i] <= mul_diff(fx_reg[i], uy_reg[(i + 1) % NUM_CORNER]);
                p_fyux_reg[i] <= mul_diff(fy_reg[i], ux_reg[(i + 1) % NUM_CORNER]);
                p_fxwy_reg[i] <= mul_diff(fx_reg[i], wy_reg[(i + 1) % NUM_CORNER]);
                p_fywx_reg[i] <= mul_diff(fy_reg[i], wx_reg[(i + 1) % NUM_CORNER]);
            end
        end
    end

    // ---------------- stage 3: cross and dot sums
    sum_t cr_reg  [NUM_CORNER];
    sum_t dt1_reg [NUM_CORNER];
    sum_t dt2_reg [NUM_CORNER];
    sum_t el_reg  [NUM_CORNER];
    sum_t l2_reg  [NUM_CORNER];
    sum_t r2_reg  [NUM_CORNER];
    logic [NUM_CORNER-1:0] box3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            box3_reg <= box2_reg;
            for (int i = 0; i < NUM_CORNER; i++)
            begin
                cr_reg[i]  <= sum_t'(p_uxdy_reg[i]) - sum_t'(p_uydx_reg[i]);
                dt1_reg[i] <= sum_t'(p_uxdx_reg[i]) + sum_t'(p_uydy_reg[i]);
                dt2_reg[i] <= sum_t'(p_wxdx_reg[i]) + sum_t'(p_wydy_reg[i]);
                el_reg[i]  <= sum_t'(p_dxwy_reg[i]) - sum_t'(p_dywx_reg[i]);
                l2_reg[i]  <= sum_t'(p_fxuy_reg[i]) - sum_t'(p_fyux_reg[i]);
                r2_reg[i]  <= sum_t'(p_fxwy_reg[i]) - sum_t'(p_fywx_reg[i]);
            end
        end
    end

    // ---------------- stage 4: tests, priority, output register
    function automatic logic is_neg(sum_t s);
        return s[SUM_W-1];
    endfunction

    function automatic logic is_pos(sum_t s);
        return !s[SUM_W-1] && (s != '0);
    endfunction

    function automatic logic same_side(sum_t l, sum_t r);
        return (is_pos(l) && is_pos(r)) || (is_neg(l) && is_neg(r));
    endfunction

    function automatic logic near_zero(sum_t s, tol_t tol);
        cmp_t x;
        cmp_t t;
        x = cmp_t'(s);
        t = cmp_t'(tol);
        return (x <= t) && (x >= -t);
    endfunction

    logic [NUM_CORNER-1:0] corner_hit;
    logic [NUM_CORNER-1:0] edge_hit;
    logic                  hit_next;
    hit_kind_t             kind_next;
    logic [1:0]            idx_next;

    always_comb
    begin
        for (int i = 0; i < NUM_CORNER; i++)
        begin
            // second dot is taken against B-A, so strictly inside means negative
            corner_hit[i] = near_zero(cr_reg[i], tol_reg) && is_pos(dt1_reg[i])
                         && is_neg(dt2_reg[i]);
            if (same_side(el_reg[i], el_reg[(i + 1) % NUM_CORNER]))
            begin
                edge_hit[i] = 1'b0;
            end
            else if (near_zero(el_reg[i], tol_reg)
                     && near_zero(el_reg[(i + 1) % NUM_CORNER], tol_reg))
            begin
                edge_hit[i] = box3_reg[i];
            end
            else
            begin
                edge_hit[i] = !same_side(l2_reg[i], r2_reg[i]);
            end
        end

        hit_next  = 1'b0;
        kind_next = KIND_NONE;
        idx_next  = 2'd0;
        // scan from the back so the lowest corner, then the lowest edge, wins
        for (int i = NUM_CORNER - 1; i >= 0; i--)
        begin
            if (edge_hit[i])
            begin
                hit_next  = 1'b1;
                kind_next = KIND_EDGE;
                idx_next  = 2'(i);
            end
        end
        for (int i = NUM_CORNER - 1; i >= 0; i--)
        begin
            if (corner_hit[i])
            begin
                hit_next  = 1'b1;
                kind_next = KIND_CORNER;
                idx_next  = 2'(i);
            end
        end
    end

    logic      hit_reg;
    hit_kind_t kind_reg;
    logic [1:0] idx_reg;

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            hit_reg  <= hit_next;
            kind_reg <= kind_next;
            idx_reg  <= idx_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'd0, idx_reg, hit_reg};
    assign m_tuser  = kind_reg;

`ifndef SYNTHESIS
    a_kind_matches_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == KIND_NONE) == !m_tdata[0]))
        else $error("hit_kind disagrees with hit");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == 2'd0))
        else $error("nonzero hit_index on a miss");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_tready))
        else $error("input stalled with a bubble in the pipeline");

    a_latency_four: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
        else $error("accepted beat did not reach the output in four cycles");
`endif

endmodule

`default_nettype wire
